// File: rtl/vpsb_pkg.sv
// shared types, constants and helpers for the particle step datapath
package vpsb_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int AXES       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // pipeline depth: kick stages, remainder entry, one stage per magnitude bit, output register
  localparam int KICK_STAGES = 5;
  localparam int DIV_STAGES  = 32;
  localparam int LATENCY     = KICK_STAGES + DIV_STAGES + 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODES     = 3'd4;

  localparam logic [30:0] TIME_STEP_RST = 31'd655;
  localparam logic [30:0] CELL_RST      = 31'd65536;
  localparam logic [2:0]  MODES_RST     = 3'b111;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [65:0] SAT_HI  = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO  = -66'sd2147483648;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic               last_particle;
  } particle_t;

  typedef struct packed {
    logic        [30:0] new_pos_x;
    logic        [30:0] new_pos_y;
    logic        [30:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               step_done;
  } result_t;

  // integrated axis state before the boundary rule
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } kick_out_t;

  // axis state after the boundary rule
  typedef struct packed {
    logic        [30:0] pos;
    logic signed [31:0] vel;
  } axis_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = S32_MAX;
    end else if (v < SAT_LO) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/vpsb_kick.sv
// one axis lane: half kicks and drift, five pipeline stages
module vpsb_kick (
  input  logic                      clk,
  input  logic [30:0]               dt,
  input  logic signed [31:0]        pos,
  input  logic signed [31:0]        vel,
  input  logic signed [31:0]        acc,
  output vpsb_pkg::kick_out_t       kick
);
  import vpsb_pkg::*;

  logic signed [31:0] dt_s;

  logic signed [63:0] prod_a;
  logic signed [31:0] v1, x1;
  logic signed [31:0] h2, v2, x2;
  logic signed [32:0] vh3;
  logic signed [31:0] h3, x3;
  logic signed [31:0] nv4, x4;
  logic signed [63:0] prod_v;
  logic signed [31:0] p5, nv5;

  logic signed [31:0] vs3;
  logic signed [32:0] vsum3;
  logic signed [63:0] delta4;
  logic signed [64:0] psum4;

  assign dt_s = $signed({1'b0, dt});

  // stage 1: a*dt
  always_ff @(posedge clk) begin
    prod_a <= 64'(acc) * 64'(dt_s);
    v1     <= vel;
    x1     <= pos;
  end

  // stage 2: half kick h = floor(a*dt / 2^(frac+1)), saturated
  always_ff @(posedge clk) begin
    h2 <= sat32(66'(prod_a >>> (FRAC_BITS + 1)));
    v2 <= v1;
    x2 <= x1;
  end

  // stage 3: unsaturated v + h for the drift
  always_ff @(posedge clk) begin
    vh3 <= 33'(v2) + 33'(h2);
    h3  <= h2;
    x3  <= x2;
  end

  // stage 4: second half kick and (v + h)*dt
  always_comb begin
    vs3   = sat32(66'(vh3));
    vsum3 = 33'(vs3) + 33'(h3);
  end

  always_ff @(posedge clk) begin
    nv4    <= sat32(66'(vsum3));
    prod_v <= 64'(vh3) * 64'(dt_s);
    x4     <= x3;
  end

  // stage 5: position update, saturated
  always_comb begin
    delta4 = prod_v >>> FRAC_BITS;
    psum4  = 65'(x4) + 65'(delta4);
  end

  always_ff @(posedge clk) begin
    p5  <= sat32(66'(psum4));
    nv5 <= nv4;
  end

  assign kick.pos = p5;
  assign kick.vel = nv5;

endmodule

// File: rtl/vpsb_bound.sv
// one axis lane: boundary rule with a bit-per-stage remainder pipeline
module vpsb_bound (
  input  logic                clk,
  input  logic [30:0]         cell_len,
  input  logic                periodic,
  input  vpsb_pkg::kick_out_t kick,
  output vpsb_pkg::axis_out_t axis
);
  import vpsb_pkg::*;

  logic [30:0]        rem  [DIV_STAGES+1];
  logic [31:0]        dvd  [DIV_STAGES+1];
  logic               neg  [DIV_STAGES+1];
  logic signed [31:0] pp   [DIV_STAGES+1];
  logic signed [31:0] vv   [DIV_STAGES+1];

  logic               in_neg;
  logic [31:0]        in_mag;

  assign in_neg = kick.pos < 0;
  assign in_mag = in_neg ? 32'(-33'(kick.pos)) : 32'(kick.pos);

  // entry stage
  always_ff @(posedge clk) begin
    rem[0] <= '0;
    dvd[0] <= in_mag;
    neg[0] <= in_neg;
    pp[0]  <= kick.pos;
    vv[0]  <= kick.vel;
  end

  // one restoring remainder step per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_rem
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;

    assign trial = {rem[k], dvd[k][31]};
    assign diff  = trial - {1'b0, cell_len};
    assign ge    = trial >= {1'b0, cell_len};

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? diff[30:0] : trial[30:0];
      dvd[k+1] <= {dvd[k][30:0], 1'b0};
      neg[k+1] <= neg[k];
      pp[k+1]  <= pp[k];
      vv[k+1]  <= vv[k];
    end
  end

  // final selection between wrap and wall
  always_comb begin
    logic [30:0]        r;
    logic signed [33:0] pe;
    logic signed [33:0] ce;
    logic signed [33:0] q;
    logic               flip;
    logic signed [31:0] v;

    r    = rem[DIV_STAGES];
    pe   = 34'(pp[DIV_STAGES]);
    ce   = $signed({3'b000, cell_len});
    v    = vv[DIV_STAGES];
    flip = 1'b0;
    q    = pe;

    if (pe < 0) begin
      q    = -pe;
      flip = 1'b1;
    end else if (pe > ce) begin
      q    = (ce <<< 1) - pe;
      flip = 1'b1;
    end
    if (q < 0) begin
      q = '0;
    end
    if (q > ce) begin
      q = ce;
    end

    if (periodic) begin
      if (cell_len == '0) begin
        axis.pos = '0;
      end else if (neg[DIV_STAGES] && r != '0) begin
        axis.pos = cell_len - r;
      end else begin
        axis.pos = r;
      end
      axis.vel = v;
    end else begin
      axis.pos = q[30:0];
      if (!flip) begin
        axis.vel = v;
      end else if (v == S32_MIN) begin
        axis.vel = S32_MAX;
      end else begin
        axis.vel = -v;
      end
    end
  end

endmodule

// File: rtl/verlet_particle_step_with_bounds_top.sv
// top level: config registers, three axis lanes and the merging output register
//
// velocity verlet step for one particle per transaction, with a boundary rule per axis
// input: drive particle and pulse start; the transaction is taken at any edge with start
//   high and busy low. busy stays low, so a new particle can enter every cycle
// output: done is high for exactly one cycle with the stepped particle on result;
//   the receiver cannot stall, so results must be taken when shown
// latency: 39 cycles from the accepting edge to the edge that ends the done cycle:
//   5 kick/drift stages, a remainder entry stage, 32 remainder stages (one bit of the
//   position magnitude each) and the merging output register
// throughput: one particle per cycle, set by the fully pipelined lanes and remainder unit
// config: cfg_we writes cfg_data to register cfg_index (0 time step, 1..3 cell sizes x/y/z,
//   4 boundary modes) at once; unused indexes are ignored. write only while no transaction
//   is in flight, since the lanes read the registers in several stages
// reset: rst clears the in-flight valid pipe (in-flight transactions are dropped) and
//   restores the config registers to dt 655, cells 1.0 and all axes periodic
module verlet_particle_step_with_bounds_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  vpsb_pkg::particle_t                 particle,
  output logic                                done,
  output vpsb_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic [vpsb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vpsb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vpsb_pkg::*;

  // configuration registers
  logic [30:0] time_step;
  logic [30:0] cell_size [AXES];
  logic [2:0]  boundary_modes;

  // per-axis views of the transaction
  logic signed [31:0] pos_in [AXES];
  logic signed [31:0] vel_in [AXES];
  logic signed [31:0] acc_in [AXES];
  kick_out_t          kick   [AXES];
  axis_out_t          axis   [AXES];

  // valid and last-particle tracking alongside the lanes
  logic [LATENCY-1:0] vld;
  logic [LATENCY-2:0] last_pipe;

  // the pipeline never refuses a transaction
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step      <= TIME_STEP_RST;
      cell_size[0]   <= CELL_RST;
      cell_size[1]   <= CELL_RST;
      cell_size[2]   <= CELL_RST;
      boundary_modes <= MODES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIME_STEP: time_step      <= cfg_data;
        CFG_CELL_X:    cell_size[0]   <= cfg_data;
        CFG_CELL_Y:    cell_size[1]   <= cfg_data;
        CFG_CELL_Z:    cell_size[2]   <= cfg_data;
        CFG_MODES:     boundary_modes <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign pos_in[0] = particle.pos_x;
  assign pos_in[1] = particle.pos_y;
  assign pos_in[2] = particle.pos_z;
  assign vel_in[0] = particle.vel_x;
  assign vel_in[1] = particle.vel_y;
  assign vel_in[2] = particle.vel_z;
  assign acc_in[0] = particle.acc_x;
  assign acc_in[1] = particle.acc_y;
  assign acc_in[2] = particle.acc_z;

  // one integrator and one boundary unit per axis
  for (genvar i = 0; i < AXES; i++) begin : g_lane
    vpsb_kick u_kick (
      .clk  (clk),
      .dt   (time_step),
      .pos  (pos_in[i]),
      .vel  (vel_in[i]),
      .acc  (acc_in[i]),
      .kick (kick[i])
    );

    vpsb_bound u_bound (
      .clk      (clk),
      .cell_len (cell_size[i]),
      .periodic (boundary_modes[i]),
      .kick     (kick[i]),
      .axis     (axis[i])
    );
  end

  // valid pipe: the only control state in the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    last_pipe <= {last_pipe[LATENCY-3:0], particle.last_particle};
  end

  // merging stage: gather the three lanes into one result
  always_ff @(posedge clk) begin
    result.new_pos_x <= axis[0].pos;
    result.new_pos_y <= axis[1].pos;
    result.new_pos_z <= axis[2].pos;
    result.new_vel_x <= axis[0].vel;
    result.new_vel_y <= axis[1].vel;
    result.new_vel_z <= axis[2].vel;
    result.step_done <= last_pipe[LATENCY-2];
  end

  assign done = vld[LATENCY-1];

  // every result traces back to an earlier transaction
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("done without a transaction LATENCY cycles earlier");

  // every accepted transaction produces its result
  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted transaction produced no result");

  // the end-of-step marker stays aligned with its particle
  a_last_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> result.step_done == $past(particle.last_particle, LATENCY))
    else $error("step_done misaligned with its transaction");

endmodule

// File: tb/verlet_particle_step_with_bounds_top_test.sv
// self-checking testbench for the velocity verlet particle step with boundary rules
module verlet_particle_step_with_bounds_top_test;
  import vpsb_pkg::*;

  localparam int ONE           = 1 << FRAC_BITS;   // 1.0 in Q16.16
  localparam int RESET_CYCLES  = 9;
  localparam int DRAIN_CYCLES  = LATENCY + 5;
  localparam int BLOCK_ITEMS   = 30;
  localparam int RANDOM_ITEMS  = 150;
  localparam int REPORT_LIMIT  = 10;
  localparam int TIMEOUT_UNITS = 2_000_000;

  // boundary mode words, one bit per axis (bit0 x), set bit means periodic wrap
  localparam logic [2:0] ALL_WRAP    = 3'b111;
  localparam logic [2:0] ALL_WALLS   = 3'b000;
  localparam logic [2:0] ONLY_Y_WRAP = 3'b010;
  localparam logic [2:0] ONLY_Y_WALL = 3'b101;
  localparam logic       WRAP_AXIS   = 1'b1;

  localparam logic [30:0] DT_MAX  = 31'h7fff_ffff;
  localparam logic [30:0] LEN_MAX = 31'h7fff_ffff;

  // saturation bounds at the predictor's working width
  localparam logic signed [95:0] WIDE_MAX = 96'sh7fff_ffff;
  localparam logic signed [95:0] WIDE_MIN = -96'sh8000_0000;

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  logic      busy;
  particle_t particle;
  logic      done;
  result_t   result;
  logic      cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // local copy of the config registers, updated as each write lands
  logic [30:0] step_dt;
  logic [30:0] box_len [3];
  logic [2:0]  wall_modes;

  result_t expected_steps [$];
  result_t pending_step;
  int      error_count = 0;
  int      gap_pct = 0;

  verlet_particle_step_with_bounds_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .particle  (particle),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop in case a result never shows up
  initial begin
    #(TIMEOUT_UNITS);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [95:0] clip_s32(input logic signed [95:0] v);
    if (v > WIDE_MAX) begin
      return WIDE_MAX;
    end
    if (v < WIDE_MIN) begin
      return WIDE_MIN;
    end
    return v;
  endfunction

  // one verlet step on all three axes under the current register copy
  function automatic result_t advance_particle(input particle_t p);
    result_t            r;
    logic signed [31:0] pos_in  [3];
    logic signed [31:0] vel_in  [3];
    logic signed [31:0] acc_in  [3];
    logic        [30:0] pos_out [3];
    logic signed [31:0] vel_out [3];
    logic signed [95:0] dt_w, len_w, acc_w, vel_w, pos_w, half_kick, coast, nv_w;
    pos_in = '{p.pos_x, p.pos_y, p.pos_z};
    vel_in = '{p.vel_x, p.vel_y, p.vel_z};
    acc_in = '{p.acc_x, p.acc_y, p.acc_z};
    dt_w = $signed({65'd0, step_dt});
    for (int ax = 0; ax < AXES; ax++) begin
      len_w = $signed({65'd0, box_len[ax]});
      acc_w = acc_in[ax];
      vel_w = vel_in[ax];
      pos_w = pos_in[ax];
      // arithmetic shifts floor toward minus infinity
      half_kick = clip_s32((acc_w * dt_w) >>> (FRAC_BITS + 1));
      coast = vel_w + half_kick;
      nv_w = clip_s32(clip_s32(coast) + half_kick);
      pos_w = clip_s32(pos_w + ((coast * dt_w) >>> FRAC_BITS));
      if (wall_modes[ax] == WRAP_AXIS) begin
        if (len_w == 0) begin
          pos_w = 0;
        end else begin
          pos_w = pos_w % len_w;
          if (pos_w < 0) begin
            pos_w = pos_w + len_w;
          end
        end
      end else begin
        if (pos_w < 0) begin
          pos_w = -pos_w;
          nv_w = clip_s32(-nv_w);
        end else if (pos_w > len_w) begin
          pos_w = 2 * len_w - pos_w;
          nv_w = clip_s32(-nv_w);
        end
        // overshoot past the mirror ends on a wall
        if (pos_w < 0) begin
          pos_w = 0;
        end
        if (pos_w > len_w) begin
          pos_w = len_w;
        end
      end
      pos_out[ax] = pos_w[30:0];
      vel_out[ax] = nv_w[31:0];
    end
    r.new_pos_x = pos_out[0];
    r.new_pos_y = pos_out[1];
    r.new_pos_z = pos_out[2];
    r.new_vel_x = vel_out[0];
    r.new_vel_y = vel_out[1];
    r.new_vel_z = vel_out[2];
    r.step_done = p.last_particle;
    return r;
  endfunction

  function automatic particle_t make_particle(input int px, input int py, input int pz,
                                              input int vx, input int vy, input int vz,
                                              input int ax, input int ay, input int az,
                                              input bit last);
    particle_t p;
    p.pos_x = px;
    p.pos_y = py;
    p.pos_z = pz;
    p.vel_x = vx;
    p.vel_y = vy;
    p.vel_z = vz;
    p.acc_x = ax;
    p.acc_y = ay;
    p.acc_z = az;
    p.last_particle = last;
    return p;
  endfunction

  // mostly within one box length of the cell, sometimes anywhere
  function automatic int random_coord(input logic [30:0] len);
    longint lo, span, pick;
    if ($urandom_range(0, 4) == 0) begin
      return $urandom;
    end
    lo = -longint'(len);
    span = 3 * longint'(len) + 1;
    pick = lo + longint'({$urandom, $urandom} % span);
    if (pick > longint'(S32_MAX)) begin
      pick = S32_MAX;
    end
    return int'(pick);
  endfunction

  // random magnitude from tiny to full scale, plus the two extremes
  function automatic int random_rate();
    int r;
    case ($urandom_range(0, 9))
      0: r = S32_MAX;
      1: r = S32_MIN;
      2: r = $urandom;
      default: begin
        r = $urandom;
        r = r >>> $urandom_range(0, 31);
      end
    endcase
    return r;
  endfunction

  function automatic logic [30:0] random_len();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(1, 64));
      1: return 31'($urandom_range(1, 16) * ONE);
      2: return 31'($urandom_range(ONE / 4, 64 * ONE));
      3: return 31'($urandom);
      4: return LEN_MAX;
      default: return 31'(ONE);
    endcase
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("mismatch: %s", what);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      flag_error($sformatf("%s expected %h got %h", name, want, got));
    end
  endtask

  // results are sampled mid-cycle, so the edge that takes them is never raced
  always @(negedge clk) begin
    if (!rst && done) begin
      if (expected_steps.size() == 0) begin
        flag_error("result with no transaction pending");
      end else begin
        pending_step = expected_steps.pop_front();
        check_field("new_pos_x", pending_step.new_pos_x, result.new_pos_x);
        check_field("new_pos_y", pending_step.new_pos_y, result.new_pos_y);
        check_field("new_pos_z", pending_step.new_pos_z, result.new_pos_z);
        check_field("new_vel_x", pending_step.new_vel_x, result.new_vel_x);
        check_field("new_vel_y", pending_step.new_vel_y, result.new_vel_y);
        check_field("new_vel_z", pending_step.new_vel_z, result.new_vel_z);
        check_field("step_done", pending_step.step_done, result.step_done);
      end
    end
  end

  // one transaction: optional sender gap, then hold start until the block takes it
  task automatic send_particle(input particle_t p);
    // each idle cycle is drawn on its own, so gap_pct is the idle share of cycles
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    particle <= p;
    start <= 1'b1;
    // busy only moves on a rising edge, so its mid-cycle value is what the edge sees
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    expected_steps.push_back(advance_particle(p));
  endtask

  // stop sending and let the pipe empty
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_steps.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TIME_STEP: step_dt = val;
      CFG_CELL_X:    box_len[0] = val;
      CFG_CELL_Y:    box_len[1] = val;
      CFG_CELL_Z:    box_len[2] = val;
      CFG_MODES:     wall_modes = val[2:0];
      default: ;
    endcase
  endtask

  // registers change only with nothing in flight
  task automatic apply_settings(input logic [30:0] dt, input logic [30:0] lx,
                                input logic [30:0] ly, input logic [30:0] lz,
                                input logic [2:0] modes);
    wait_for_results();
    write_register(CFG_TIME_STEP, dt);
    write_register(CFG_CELL_X, lx);
    write_register(CFG_CELL_Y, ly);
    write_register(CFG_CELL_Z, lz);
    write_register(CFG_MODES, {28'd0, modes});
  endtask

  // reset values: dt 0.01, unit cells, all axes periodic
  task automatic test_reset_config();
    send_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_particle(make_particle(ONE / 2, ONE / 3, ONE - 1, ONE, -2 * ONE, 50 * ONE,
                                2 * ONE, -ONE, 300 * ONE, 1'b0));
    // negative positions wrap back into the cell
    send_particle(make_particle(-ONE / 4, -5 * ONE, -1, -3 * ONE, 0, -ONE,
                                -ONE, 0, -7 * ONE, 1'b1));
  endtask

  // full-scale dt drives the kicks and the drift into saturation
  task automatic test_saturation();
    apply_settings(DT_MAX, 31'(ONE), 31'(ONE), 31'(ONE), ALL_WRAP);
    send_particle(make_particle(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                                S32_MAX, S32_MAX, S32_MAX, 1'b1));
    send_particle(make_particle(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                                S32_MIN, S32_MIN, S32_MIN, 1'b0));
    send_particle(make_particle(0, -1, 1, S32_MAX, S32_MIN, 0,
                                S32_MIN, S32_MAX, S32_MAX, 1'b0));
    apply_settings(DT_MAX, 31'(ONE), 31'(ONE), 31'(ONE), ALL_WALLS);
    send_particle(make_particle(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                                S32_MAX, S32_MAX, S32_MAX, 1'b0));
    send_particle(make_particle(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                                S32_MIN, S32_MIN, S32_MIN, 1'b1));
  endtask

  // mirror below zero, mirror above the cell, overshoot past the mirror,
  // negation of the most negative velocity
  task automatic test_reflecting_walls();
    apply_settings(31'(ONE), 31'(4 * ONE), 31'(4 * ONE), 31'(4 * ONE), ALL_WALLS);
    send_particle(make_particle(ONE / 2, 7 * ONE / 2, ONE, -ONE, ONE, -10 * ONE,
                                0, 0, 0, 1'b0));
    // z sits exactly on the lower wall, x overshoots the upper one
    send_particle(make_particle(3 * ONE, 4 * ONE, 0, 10 * ONE, 0, 0,
                                ONE, -ONE, 0, 1'b0));
    send_particle(make_particle(0, 0, ONE, S32_MIN, S32_MAX, S32_MIN,
                                0, 0, 0, 1'b1));
    // mixed axes: x and z wrap, y reflects
    apply_settings(31'(ONE), 31'(4 * ONE), 31'(4 * ONE), 31'(4 * ONE), ONLY_Y_WALL);
    send_particle(make_particle(-ONE / 2, -ONE / 2, 5 * ONE, -ONE, -ONE, ONE,
                                -ONE, ONE, 2 * ONE, 1'b0));
  endtask

  // zero length: wrap gives 0, wall clamps to 0
  task automatic test_zero_cell();
    apply_settings(31'(ONE), 31'd0, 31'd0, 31'd0, ONLY_Y_WRAP);
    send_particle(make_particle(ONE, ONE, -ONE, ONE, -ONE, ONE, 0, 0, 0, 1'b0));
    send_particle(make_particle(S32_MAX, S32_MIN, 0, S32_MIN, S32_MAX, -1,
                                ONE, ONE, ONE, 1'b1));
  endtask

  // largest cells with dt 0: positions pass straight to the boundary rule
  task automatic test_wide_cell();
    apply_settings(31'd0, LEN_MAX, LEN_MAX, LEN_MAX, ALL_WALLS);
    send_particle(make_particle(S32_MIN, S32_MAX, 0, S32_MIN, 1, -1,
                                S32_MAX, S32_MIN, 0, 1'b0));
    send_particle(make_particle(S32_MAX, -1, S32_MIN, 0, 0, 0, 0, 0, 0, 1'b1));
    apply_settings(31'd0, LEN_MAX, LEN_MAX, LEN_MAX, ALL_WRAP);
    send_particle(make_particle(S32_MIN, S32_MAX, 0, S32_MIN, 1, -1,
                                S32_MAX, S32_MIN, 0, 1'b0));
    send_particle(make_particle(S32_MAX, -1, S32_MIN, 0, 0, 0, 0, 0, 0, 1'b1));
  endtask

  // random particles in blocks, fresh random settings before each block
  task automatic test_random_traffic(input int idle_pct);
    logic [30:0] dt_pick;
    gap_pct = idle_pct;
    for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
      case ($urandom_range(0, 4))
        0: dt_pick = 31'($urandom_range(0, ONE / 64));
        1: dt_pick = 31'($urandom_range(0, 2 * ONE));
        2: dt_pick = 31'($urandom);
        3: dt_pick = DT_MAX;
        default: dt_pick = TIME_STEP_RST;
      endcase
      apply_settings(dt_pick, random_len(), random_len(), random_len(),
                     3'($urandom_range(0, 7)));
      repeat (BLOCK_ITEMS) begin
        send_particle(make_particle(random_coord(box_len[0]), random_coord(box_len[1]),
                                    random_coord(box_len[2]), random_rate(), random_rate(),
                                    random_rate(), random_rate(), random_rate(),
                                    random_rate(), $urandom_range(0, 7) == 0));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    particle <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    step_dt = TIME_STEP_RST;
    box_len = '{CELL_RST, CELL_RST, CELL_RST};
    wall_modes = MODES_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_saturation();
    test_reflecting_walls();
    test_zero_cell();
    test_wide_cell();
    // sender idles often, then more often, then streams back to back
    test_random_traffic(28);
    test_random_traffic(61);
    test_random_traffic(0);

    wait_for_results();
    // stray results after the last expected one still get caught
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_steps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/vpsb_pkg.sv
rtl/vpsb_kick.sv
rtl/vpsb_bound.sv
rtl/verlet_particle_step_with_bounds_top.sv
tb/verlet_particle_step_with_bounds_top_test.sv
